// ===== rtl/core/lfa_pkg.sv =====
// ----------------------------------------------------------------------------
// LRU frame allocator package
// Shared types and constants for the frame allocator controller and datapath.
// ----------------------------------------------------------------------------
package lfa_pkg;

   localparam int FRAME_BITS_DEFAULT = 4;
   localparam int AGE_W              = 32;
   localparam int INDEX_W            = 4;
   localparam int MODE_W             = 2;

   localparam logic [AGE_W-1:0] AGE_MAX = '1;

   typedef enum logic [MODE_W-1:0] {
      MODE_ALLOC = 2'd0,
      MODE_TOUCH = 2'd1,
      MODE_CLEAR = 2'd2,
      MODE_NONE  = 2'd3
   } mode_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_SEARCH,
      ST_SEARCH_END,
      ST_PICK,
      ST_UPDATE,
      ST_UPDATE_END,
      ST_WIPE,
      ST_RESPOND
   } state_type;

   typedef struct packed {
      logic start;
      logic issue;
      logic update;
      logic clear_wr;
      logic pick;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic cnt_last;
   } status_type;

endpackage

// ===== rtl/core/lfa_datapath.sv =====
// ----------------------------------------------------------------------------
// LRU frame allocator datapath
// Age memory, sweep counter, oldest/empty search and the clear and age update writes.
// ----------------------------------------------------------------------------
module lfa_datapath #(
   parameter int FRAME_BITS = lfa_pkg::FRAME_BITS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  lfa_pkg::cmd_type            cmd,
   output lfa_pkg::status_type         status,
   input  logic [lfa_pkg::MODE_W-1:0]  req_mode,
   input  logic [lfa_pkg::INDEX_W-1:0] req_frame_index,
   output logic [lfa_pkg::INDEX_W-1:0] rsp_chosen_frame,
   output logic                        rsp_was_empty
);

   localparam int FRAME_COUNT = 1 << FRAME_BITS;

   logic [lfa_pkg::AGE_W-1:0] age_mem [FRAME_COUNT];

   logic [FRAME_BITS-1:0]     cnt_ff;
   logic [FRAME_BITS-1:0]     cnt_in;
   logic                      rd_valid_ff;
   logic                      rd_upd_ff;
   logic [FRAME_BITS-1:0]     rd_idx_ff;
   logic [lfa_pkg::AGE_W-1:0] rd_data_ff;

   lfa_pkg::mode_type         mode_ff;
   logic [FRAME_BITS-1:0]     target_ff;
   logic                      empty_found_ff;
   logic [FRAME_BITS-1:0]     empty_idx_ff;
   logic [FRAME_BITS-1:0]     best_idx_ff;
   logic [lfa_pkg::AGE_W-1:0] best_age_ff;
   logic [lfa_pkg::INDEX_W-1:0] chosen_ff;
   logic                      was_empty_ff;

   logic                      wr_en;
   logic [FRAME_BITS-1:0]     wr_addr;
   logic [lfa_pkg::AGE_W-1:0] wr_data;
   logic [lfa_pkg::AGE_W-1:0] aged;
   logic                      search_hit;
   logic                      update_hit;

   assign cnt_in          = cnt_ff + FRAME_BITS'(1);
   assign status.cnt_last = (cnt_ff == FRAME_BITS'(FRAME_COUNT - 1));
   assign search_hit      = rd_valid_ff && !rd_upd_ff;
   assign update_hit      = rd_valid_ff && rd_upd_ff;

   always_comb begin
      if ((rd_data_ff != '0) && (rd_data_ff != lfa_pkg::AGE_MAX)) begin
         aged = rd_data_ff + lfa_pkg::AGE_W'(1);
      end else begin
         aged = rd_data_ff;
      end
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = rd_idx_ff;
      wr_data = aged;
      if (cmd.clear_wr) begin
         wr_en   = 1'b1;
         wr_addr = cnt_ff;
         wr_data = '0;
      end else if (update_hit) begin
         wr_en = 1'b1;
         if (rd_idx_ff == target_ff) begin
            wr_data = lfa_pkg::AGE_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         age_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= age_mem[cnt_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff      <= '0;
         rd_valid_ff <= 1'b0;
         rd_upd_ff   <= 1'b0;
      end else begin
         if (cmd.issue || cmd.clear_wr) begin
            cnt_ff <= cnt_in;
         end
         rd_valid_ff <= cmd.issue;
         rd_upd_ff   <= cmd.update;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= cnt_ff;
      if (cmd.start) begin
         mode_ff        <= lfa_pkg::mode_type'(req_mode);
         target_ff      <= FRAME_BITS'(req_frame_index);
         empty_found_ff <= 1'b0;
      end else if (cmd.pick) begin
         target_ff <= empty_found_ff ? empty_idx_ff : best_idx_ff;
      end
      if (search_hit) begin
         if ((rd_data_ff == '0) && !empty_found_ff) begin
            empty_found_ff <= 1'b1;
            empty_idx_ff   <= rd_idx_ff;
         end
         if ((rd_idx_ff == '0) || (rd_data_ff > best_age_ff)) begin
            best_age_ff <= rd_data_ff;
            best_idx_ff <= rd_idx_ff;
         end
      end
      if (cmd.load_rsp) begin
         if ((mode_ff == lfa_pkg::MODE_ALLOC) || (mode_ff == lfa_pkg::MODE_TOUCH)) begin
            chosen_ff <= lfa_pkg::INDEX_W'(target_ff);
         end else begin
            chosen_ff <= '0;
         end
         was_empty_ff <= (mode_ff == lfa_pkg::MODE_ALLOC) && empty_found_ff;
      end
   end

   assign rsp_chosen_frame = chosen_ff;
   assign rsp_was_empty    = was_empty_ff;

endmodule

// ===== rtl/core/lfa_ctrl.sv =====
// ----------------------------------------------------------------------------
// LRU frame allocator controller
// Sequences the clear, search and update sweeps and the result handshake.
// ----------------------------------------------------------------------------
module lfa_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic [lfa_pkg::MODE_W-1:0] req_mode,
   output logic                       req_stall,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  lfa_pkg::status_type        status,
   output lfa_pkg::cmd_type           cmd
);

   lfa_pkg::state_type state_ff;
   lfa_pkg::state_type state_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic               rsp_free;

   assign rsp_free     = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = cmd.load_rsp || (rsp_valid_ff && rsp_stall);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lfa_pkg::ST_INIT: begin
            if (status.cnt_last) begin
               state_in = lfa_pkg::ST_IDLE;
            end
         end
         lfa_pkg::ST_IDLE: begin
            if (req_valid) begin
               case (lfa_pkg::mode_type'(req_mode))
                  lfa_pkg::MODE_ALLOC: state_in = lfa_pkg::ST_SEARCH;
                  lfa_pkg::MODE_TOUCH: state_in = lfa_pkg::ST_UPDATE;
                  lfa_pkg::MODE_CLEAR: state_in = lfa_pkg::ST_WIPE;
                  default:             state_in = lfa_pkg::ST_RESPOND;
               endcase
            end
         end
         lfa_pkg::ST_SEARCH: begin
            if (status.cnt_last) begin
               state_in = lfa_pkg::ST_SEARCH_END;
            end
         end
         lfa_pkg::ST_SEARCH_END: state_in = lfa_pkg::ST_PICK;
         lfa_pkg::ST_PICK:       state_in = lfa_pkg::ST_UPDATE;
         lfa_pkg::ST_UPDATE: begin
            if (status.cnt_last) begin
               state_in = lfa_pkg::ST_UPDATE_END;
            end
         end
         lfa_pkg::ST_UPDATE_END: state_in = lfa_pkg::ST_RESPOND;
         lfa_pkg::ST_WIPE: begin
            if (status.cnt_last) begin
               state_in = lfa_pkg::ST_RESPOND;
            end
         end
         lfa_pkg::ST_RESPOND: begin
            if (rsp_free) begin
               state_in = lfa_pkg::ST_IDLE;
            end
         end
         default: state_in = lfa_pkg::ST_INIT;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         lfa_pkg::ST_INIT: cmd.clear_wr = 1'b1;
         lfa_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cmd.start = req_valid;
         end
         lfa_pkg::ST_SEARCH: cmd.issue = 1'b1;
         lfa_pkg::ST_PICK:   cmd.pick  = 1'b1;
         lfa_pkg::ST_UPDATE: begin
            cmd.issue  = 1'b1;
            cmd.update = 1'b1;
         end
         lfa_pkg::ST_WIPE:    cmd.clear_wr = 1'b1;
         lfa_pkg::ST_RESPOND: cmd.load_rsp = rsp_free;
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lfa_pkg::ST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/core/lru_frame_allocator.sv =====
// ----------------------------------------------------------------------------
// LRU frame allocator
// Per-frame age counters with allocate, touch and clear requests.
// ----------------------------------------------------------------------------
// The ages of the N = 2**FRAME_BITS frames live in a single-port-write,
// single-port-read memory that the block sweeps one frame per cycle. After
// reset a clearing pass over all N frames runs before any item is taken.
// An allocate runs one sweep to find the empty or oldest frame and one
// sweep to rewrite the ages, a touch runs only the rewrite sweep, a clear
// one sweep that zeroes every age, and an unused mode goes straight to the
// result. The next item is taken only once the result is loaded; a result
// may wait in the output register while the next item is accepted.
module lru_frame_allocator #(
   parameter int FRAME_BITS = lfa_pkg::FRAME_BITS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [lfa_pkg::MODE_W-1:0]  req_mode,
   input  logic [lfa_pkg::INDEX_W-1:0] req_frame_index,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [lfa_pkg::INDEX_W-1:0] rsp_chosen_frame,
   output logic                        rsp_was_empty
);

   lfa_pkg::cmd_type    cmd;
   lfa_pkg::status_type status;

   lfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   lfa_datapath #(
      .FRAME_BITS (FRAME_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_mode         (req_mode),
      .req_frame_index  (req_frame_index),
      .rsp_chosen_frame (rsp_chosen_frame),
      .rsp_was_empty    (rsp_was_empty)
   );

   // An accepted item always makes the block busy in the next cycle.
   a_busy_after_accept: assert property (
      @(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall
   ) else $error("input side not stalled after an accepted item");

   // A waiting result is never overwritten.
   a_no_overwrite: assert property (
      @(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid || !rsp_stall)
   ) else $error("result register loaded while a result is pending");

   // The pick happens only after the search reads have drained.
   a_pick_after_drain: assert property (
      @(posedge clock) disable iff (reset)
      cmd.pick |-> !$past(cmd.issue)
   ) else $error("frame picked while search reads were in flight");

endmodule
